// ----- hw/rtl/cms_pkg.sv -----
// shared types and constants of the count-min sketch block
package cms_pkg;

    // operation codes of the func field
    localparam logic [1:0] FUNC_UPDATE   = 2'd0;
    localparam logic [1:0] FUNC_ESTIMATE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    // hash register file
    localparam int NUM_HASH    = 3;
    localparam int HASH_IDX_W  = 2;
    localparam int CFG_ADDR_W  = 6;
    localparam int WIDTH_REG_W = 13;

    // register indexes
    localparam logic [2:0] REG_MULT_0 = 3'd0;
    localparam logic [2:0] REG_ADD_0  = 3'd1;
    localparam logic [2:0] REG_MULT_1 = 3'd2;
    localparam logic [2:0] REG_ADD_1  = 3'd3;
    localparam logic [2:0] REG_MULT_2 = 3'd4;
    localparam logic [2:0] REG_ADD_2  = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;

    localparam logic [63:0] HASH_MULT_RST = 64'd1;
    localparam logic [63:0] HASH_ADD_RST  = 64'd0;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 13'd4096;

    localparam logic signed [31:0] CNT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;

    // partial product selects of the 64-bit multiply
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_LO_HI = 2'd1;
    localparam logic [1:0] MUL_HI_LO = 2'd2;

    // remainder unit runs one hash bit per cycle
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd63;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;      // latch the input request
        logic       mul_en;    // accumulate one partial product
        logic [1:0] mul_sel;   // which partial product
        logic       hash_init; // add the row addend, clear remainder
        logic       div_step;  // one remainder step
        logic       rd_en;     // read the selected counter
        logic       apply;     // write back or fold into minimum
        logic       row_next;  // move to the next row
        logic       clr_en;    // zero one column of every row
        logic       res_load;  // load the result register
    } cms_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       row_last;
        logic       clr_last;
        logic       out_busy;
    } cms_sts_t;

endpackage

// ----- hw/rtl/cms_regs.sv -----
// configuration register file with its APB-style port
module cms_regs
    import cms_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [CFG_ADDR_W-1:0]             paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready,
    output logic [NUM_HASH-1:0][63:0]         hash_mult,
    output logic [NUM_HASH-1:0][63:0]         hash_add,
    output logic [WIDTH_REG_W-1:0]            width_in_use
);

    logic [NUM_HASH-1:0][63:0]   mult_reg;
    logic [NUM_HASH-1:0][63:0]   add_reg;
    logic [WIDTH_REG_W-1:0]      width_reg;
    logic [2:0]                  idx;
    logic                        wr_en;

    assign idx    = paddr[5:3];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_HASH; i++) begin
                mult_reg[i] <= HASH_MULT_RST;
                add_reg[i]  <= HASH_ADD_RST;
            end
            width_reg <= WIDTH_RST;
        end else if (wr_en) begin
            case (idx)
                REG_MULT_0: mult_reg[0] <= pwdata;
                REG_ADD_0:  add_reg[0]  <= pwdata;
                REG_MULT_1: mult_reg[1] <= pwdata;
                REG_ADD_1:  add_reg[1]  <= pwdata;
                REG_MULT_2: mult_reg[2] <= pwdata;
                REG_ADD_2:  add_reg[2]  <= pwdata;
                REG_WIDTH:  width_reg   <= pwdata[WIDTH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_MULT_0: prdata = mult_reg[0];
            REG_ADD_0:  prdata = add_reg[0];
            REG_MULT_1: prdata = mult_reg[1];
            REG_ADD_1:  prdata = add_reg[1];
            REG_MULT_2: prdata = mult_reg[2];
            REG_ADD_2:  prdata = add_reg[2];
            REG_WIDTH:  prdata = 64'(width_reg);
            default:    prdata = 64'd0;
        endcase
    end

    assign hash_mult    = mult_reg;
    assign hash_add     = add_reg;
    assign width_in_use = width_reg;

endmodule

// ----- hw/rtl/cms_dp.sv -----
// datapath: hash multiply, remainder unit, counter banks and result register
module cms_dp
    import cms_pkg::*;
#(
    parameter int ROWS      = 3,
    parameter int WIDTH_MAX = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cms_cmd_t                      cmd,
    output cms_sts_t                      sts,
    input  logic [1:0]                    s_func,
    input  logic [63:0]                   s_item_key,
    input  logic signed [31:0]            s_count_delta,
    input  logic [NUM_HASH-1:0][63:0]     hash_mult,
    input  logic [NUM_HASH-1:0][63:0]     hash_add,
    input  logic [WIDTH_REG_W-1:0]        width_in_use,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic signed [31:0]            m_estimate_value
);

    localparam int CW  = $clog2(WIDTH_MAX);
    localparam int EW  = CW + 1;
    localparam int RBW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CW-1:0]  CLR_LAST = CW'(WIDTH_MAX - 1);
    localparam logic [RBW-1:0] ROW_LAST = RBW'(ROWS - 1);

    logic [1:0]               func_reg;
    logic [63:0]              key_reg;
    logic signed [31:0]       delta_reg;
    logic [RBW-1:0]           row_reg;
    logic [63:0]              acc_reg;
    logic [63:0]              hash_reg;
    logic [CW-1:0]            rem_reg;
    logic [CW-1:0]            clr_addr_reg;
    logic signed [31:0]       min_reg;
    logic                     valid_reg;
    logic signed [31:0]       res_reg;
    logic [ROWS-1:0][31:0]    rd_reg;

    logic [HASH_IDX_W-1:0]    hidx;
    logic [63:0]              mult_sel;
    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [63:0]              prod;
    logic [EW-1:0]            eff_w;
    logic [EW-1:0]            rem_sh;
    logic signed [31:0]       cur;
    logic signed [32:0]       sum;
    logic signed [31:0]       sat;
    logic [CW-1:0]            mem_addr;

    assign hidx     = HASH_IDX_W'(row_reg);
    assign mult_sel = hash_mult[hidx];

    // effective modulus: zero acts as one, capped at the row depth
    always_comb begin
        if (width_in_use == '0) begin
            eff_w = EW'(1);
        end else if (32'(width_in_use) > WIDTH_MAX) begin
            eff_w = EW'(WIDTH_MAX);
        end else begin
            eff_w = EW'(width_in_use);
        end
    end

    // shared 32x32 multiplier for the low 64 bits of mult * key
    always_comb begin
        case (cmd.mul_sel)
            MUL_LO_LO: begin mul_a = mult_sel[31:0];  mul_b = key_reg[31:0];  end
            MUL_LO_HI: begin mul_a = mult_sel[31:0];  mul_b = key_reg[63:32]; end
            MUL_HI_LO: begin mul_a = mult_sel[63:32]; mul_b = key_reg[31:0];  end
            default:   begin mul_a = '0;              mul_b = '0;             end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    assign rem_sh = {rem_reg, hash_reg[63]};

    // request capture, hash and remainder
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            key_reg   <= s_item_key;
            delta_reg <= s_count_delta;
            min_reg   <= CNT_MAX;
        end
        if (cmd.mul_en) begin
            if (cmd.mul_sel == MUL_LO_LO) begin
                acc_reg <= prod;
            end else begin
                acc_reg <= {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
            end
        end
        if (cmd.hash_init) begin
            hash_reg <= acc_reg + hash_add[hidx];
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            hash_reg <= {hash_reg[62:0], 1'b0};
            if (rem_sh >= eff_w) begin
                rem_reg <= CW'(rem_sh - eff_w);
            end else begin
                rem_reg <= CW'(rem_sh);
            end
        end
        if (cmd.apply && func_reg == FUNC_ESTIMATE && cur < min_reg) begin
            min_reg <= cur;
        end
        if (cmd.res_load) begin
            res_reg <= min_reg;
        end
    end

    // row and clear address counters, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            clr_addr_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                row_reg <= '0;
            end else if (cmd.row_next) begin
                row_reg <= row_reg + 1'b1;
            end
            if (cmd.clr_en) begin
                clr_addr_reg <= (clr_addr_reg == CLR_LAST) ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.res_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // saturating add on the selected counter
    assign cur = rd_reg[row_reg];
    assign sum = {cur[31], cur} + {delta_reg[31], delta_reg};
    always_comb begin
        if (sum[32] != sum[31]) begin
            sat = sum[32] ? CNT_MIN : CNT_MAX;
        end else begin
            sat = sum[31:0];
        end
    end

    assign mem_addr = cmd.clr_en ? clr_addr_reg : rem_reg;

    // one counter bank per row
    for (genvar r = 0; r < ROWS; r++) begin : g_bank
        logic [31:0] mem [WIDTH_MAX];
        logic        we;
        logic        re;

        assign we = cmd.clr_en || (cmd.apply && func_reg == FUNC_UPDATE
                                   && row_reg == RBW'(r));
        assign re = cmd.rd_en && row_reg == RBW'(r);

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[mem_addr] <= cmd.clr_en ? 32'd0 : sat;
            end
            if (re) begin
                rd_reg[r] <= mem[mem_addr];
            end
        end
    end

    assign sts.func     = func_reg;
    assign sts.row_last = (row_reg == ROW_LAST);
    assign sts.clr_last = (clr_addr_reg == CLR_LAST);
    assign sts.out_busy = valid_reg & ~m_ready;

    assign m_valid          = valid_reg;
    assign m_estimate_value = res_reg;

endmodule

// ----- hw/rtl/cms_ctrl.sv -----
// controller state machine sequencing rows, remainder steps and clears
module cms_ctrl
    import cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [1:0]  s_func,
    output logic        s_ready,
    output cms_cmd_t    cmd,
    input  cms_sts_t    sts
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_MUL0   = 4'd2;
    localparam logic [3:0] ST_MUL1   = 4'd3;
    localparam logic [3:0] ST_MUL2   = 4'd4;
    localparam logic [3:0] ST_HASH   = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_READ   = 4'd7;
    localparam logic [3:0] ST_APPLY  = 4'd8;
    localparam logic [3:0] ST_RESULT = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_func)
                        FUNC_UPDATE, FUNC_ESTIMATE: state_next = ST_MUL0;
                        FUNC_CLEAR:                 state_next = ST_CLEAR;
                        default:                    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO_LO;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO_HI;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI_LO;
                state_next  = ST_HASH;
            end
            ST_HASH: begin
                cmd.hash_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                if (!sts.row_last) begin
                    cmd.row_next = 1'b1;
                    state_next   = ST_MUL0;
                end else if (sts.func == FUNC_ESTIMATE) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/count_min_sketch.sv -----
// top level of the count-min sketch block
//
// Requests enter on the s_ channel (s_func, s_item_key, s_count_delta) under
// valid/ready. An update adds s_count_delta, saturating, to the selected
// counter of each row; an estimate returns the minimum of those counters on
// the m_ channel; a clear zeroes every counter; func 3 is dropped.
// Hash multipliers, addends and the modulus are written over the APB port.
// Each row takes three passes through one shared 32x32 multiplier, an
// addend step, a radix-2 remainder unit, and a read then a write-back
// (update) or a fold into the minimum (estimate) on that row's counter
// bank. An estimate then loads the result register. A clear sweeps all
// rows together one column a cycle. After reset the same sweep zeroes
// the counters and s_ready stays low. A stalled receiver holds the result
// in the output register; the next request is still taken and runs up to
// its own result.
module count_min_sketch
    import cms_pkg::*;
#(
    parameter int ROWS      = 3,
    parameter int WIDTH_MAX = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_func,
    input  logic [63:0]             s_item_key,
    input  logic signed [31:0]      s_count_delta,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_estimate_value,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    logic [NUM_HASH-1:0][63:0] hash_mult;
    logic [NUM_HASH-1:0][63:0] hash_add;
    logic [WIDTH_REG_W-1:0]    width_in_use;
    cms_cmd_t                  cmd;
    cms_sts_t                  sts;

    // configuration registers
    cms_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .hash_mult    (hash_mult),
        .hash_add     (hash_add),
        .width_in_use (width_in_use)
    );

    // sequencer
    cms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath and counter banks
    cms_dp #(
        .ROWS      (ROWS),
        .WIDTH_MAX (WIDTH_MAX)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_func           (s_func),
        .s_item_key       (s_item_key),
        .s_count_delta    (s_count_delta),
        .hash_mult        (hash_mult),
        .hash_add         (hash_add),
        .width_in_use     (width_in_use),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_estimate_value (m_estimate_value)
    );

endmodule
